[sv/ncg_pkg.sv]
`timescale 1ns / 1ps

package ncg_pkg;

    // Q30 fixed point constants
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] Q30_HALF    = 31'h2000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // saturation limits of the coefficient conversion
    localparam logic signed [34:0] SAT_Q30 = 35'sd2147376273;
    localparam logic [31:0]        POS_SAT = 32'h0000_7FFF;
    localparam logic [31:0]        NEG_SAT = 32'hFFFF_8000;

    // reset value of the sample rate register
    localparam logic [9:0] FS_RESET = 10'd500;

    // control bits that travel with each cosine pipeline stage
    typedef struct packed {
        logic valid;
        logic is_cos;
        logic neg;
    } cos_ctl_t;

    // horner steps of the series evaluation
    typedef enum logic [1:0] {
        SER_STEP_A = 2'd0,
        SER_STEP_B = 2'd1,
        SER_STEP_C = 2'd2
    } ser_step_t;

    // divisor of each horner step, cosine or sine series
    function automatic logic [5:0] ser_div(input logic is_cos, input ser_step_t step);
        logic [5:0] d;
        unique case (step)
            SER_STEP_A: d = is_cos ? 6'd56 : 6'd42;
            SER_STEP_B: d = is_cos ? 6'd30 : 6'd20;
            SER_STEP_C: d = is_cos ? 6'd12 : 6'd6;
            default:    d = 6'd1;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for the reciprocal estimate
    function automatic logic [29:0] ser_recip(input logic is_cos, input ser_step_t step);
        logic [29:0] m;
        unique case (step)
            SER_STEP_A: m = is_cos ? 30'd76695844  : 30'd102261126;
            SER_STEP_B: m = is_cos ? 30'd143165576 : 30'd214748364;
            SER_STEP_C: m = is_cos ? 30'd357913941 : 30'd715827882;
            default:    m = 30'd0;
        endcase
        return m;
    endfunction

endpackage

[sv/ncg_cos.sv]
`timescale 1ns / 1ps

module ncg_cos
    import ncg_pkg::*;
#(
    parameter int PHASE_BITS = 16,
    parameter int TAG_W      = 30
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [PHASE_BITS-1:0]   phase,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic signed [15:0]      cos_q15,
    output logic [TAG_W-1:0]        out_tag
);

    localparam int LAST = 12;

    cos_ctl_t         ctl_pipe [0:LAST];
    logic [TAG_W-1:0] tag_pipe [0:LAST];
    logic [29:0]      x_pipe   [1:11];
    logic [29:0]      x2_pipe  [2:11];

    logic [29:0] a_reg;
    logic [27:0] qe_a_reg, qe_b_reg, qe_c_reg;
    logic [29:0] v_a_reg, v_b_reg, v_c_reg, v_b2_reg, v_c2_reg;
    logic [30:0] h_a_reg, h_b_reg, h_c_reg;
    logic [30:0] mag_reg;
    logic signed [15:0] cos_reg;

    // reciprocal estimate of v / d, low by at most one
    function automatic logic [27:0] div_est(input logic [29:0] v, input logic [29:0] m);
        logic [59:0] pr;
        pr = 60'(v) * 60'(m);
        return pr[59:32];
    endfunction

    // correct the estimate and form one minus the quotient
    function automatic logic [30:0] div_fix(input logic [29:0] v, input logic [27:0] qe,
                                            input logic [5:0] d);
        logic [33:0] r;
        logic [28:0] q;
        r = 34'(v) - 34'(qe) * 34'(d);
        q = (r >= 34'(d)) ? 29'(qe) + 29'd1 : 29'(qe);
        return Q30_ONE - 31'(q);
    endfunction

    // q30 product, truncated
    function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
        logic [60:0] pr;
        pr = 61'(a) * 61'(b);
        return pr[59:30];
    endfunction

    // fold the phase into one octant
    logic [31:0] p32;
    logic [30:0] t_in, tq;
    logic        in_is_cos, in_neg;
    logic [29:0] a_in;

    always_comb
    begin
        p32       = {phase, {(32-PHASE_BITS){1'b0}}};
        t_in      = {1'b0, p32[29:0]};
        tq        = p32[30] ? (Q30_ONE - t_in) : t_in;
        in_is_cos = (tq <= Q30_HALF);
        a_in      = in_is_cos ? tq[29:0] : 30'(Q30_ONE - tq);
        in_neg    = (p32[31:30] == 2'd1) || (p32[31:30] == 2'd2);
    end

    // last series step and rounding to q1.15
    logic [29:0] d_op, d_prod;
    logic [30:0] mag_nx;
    logic [31:0] rnd;
    logic [15:0] m15;

    always_comb
    begin
        d_op   = ctl_pipe[10].is_cos ? x2_pipe[10] : x_pipe[10];
        d_prod = mul_q30(d_op, h_c_reg);
        mag_nx = ctl_pipe[10].is_cos ? (Q30_ONE - 31'(d_prod[29:1])) : 31'(d_prod);
        rnd    = 32'(mag_reg) + 32'h0000_4000;
        m15    = (rnd[31:15] > 17'd32767) ? 16'd32767 : rnd[30:15];
    end

    // control chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                ctl_pipe[i] <= '0;
            end
        end
        else
        begin
            ctl_pipe[0] <= '{valid: in_valid, is_cos: in_is_cos, neg: in_neg};
            for (int i = 1; i <= LAST; i++)
            begin
                ctl_pipe[i] <= ctl_pipe[i-1];
            end
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        tag_pipe[0] <= in_tag;
        for (int i = 1; i <= LAST; i++)
        begin
            tag_pipe[i] <= tag_pipe[i-1];
        end
        for (int i = 2; i <= 11; i++)
        begin
            x_pipe[i] <= x_pipe[i-1];
        end
        for (int i = 3; i <= 11; i++)
        begin
            x2_pipe[i] <= x2_pipe[i-1];
        end

        a_reg      <= a_in;
        x_pipe[1]  <= mul_q30(a_reg, HALF_PI_Q30);
        x2_pipe[2] <= mul_q30(x_pipe[1], {1'b0, x_pipe[1]});

        // first horner step
        qe_a_reg <= div_est(x2_pipe[2], ser_recip(ctl_pipe[2].is_cos, SER_STEP_A));
        v_a_reg  <= x2_pipe[2];
        h_a_reg  <= div_fix(v_a_reg, qe_a_reg, ser_div(ctl_pipe[3].is_cos, SER_STEP_A));

        // second horner step
        v_b_reg  <= mul_q30(x2_pipe[4], h_a_reg);
        qe_b_reg <= div_est(v_b_reg, ser_recip(ctl_pipe[5].is_cos, SER_STEP_B));
        v_b2_reg <= v_b_reg;
        h_b_reg  <= div_fix(v_b2_reg, qe_b_reg, ser_div(ctl_pipe[6].is_cos, SER_STEP_B));

        // third horner step
        v_c_reg  <= mul_q30(x2_pipe[7], h_b_reg);
        qe_c_reg <= div_est(v_c_reg, ser_recip(ctl_pipe[8].is_cos, SER_STEP_C));
        v_c2_reg <= v_c_reg;
        h_c_reg  <= div_fix(v_c2_reg, qe_c_reg, ser_div(ctl_pipe[9].is_cos, SER_STEP_C));

        mag_reg <= mag_nx;
        cos_reg <= ctl_pipe[11].neg ? $signed(16'd0 - m15) : $signed(m15);
    end

    assign out_valid = ctl_pipe[LAST].valid;
    assign cos_q15   = cos_reg;
    assign out_tag   = tag_pipe[LAST];

endmodule

[sv/notch_filter_coefficient_generator.sv]
`timescale 1ns / 1ps
// done pulses once a taken start has passed the phase divider, the cosine pipeline and the output stage registers
// throughput: one transaction per cycle, busy stays low, the receiver cannot stall
// the phase divider retires four quotient bits per stage, the cosine series takes 13 stages
// reset: all valid bits clear, sample rate register returns to 500 MHz
// data registers are not reset

module notch_filter_coefficient_generator
    import ncg_pkg::*;
#(
    parameter int FRACTION_BITS = 14,
    parameter int PHASE_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] notch_freq,
    input  logic [15:0] pole_radius,
    input  logic        cfg_write,
    input  logic [9:0]  sample_rate_mhz,
    output logic        done,
    output logic [31:0] coeff_word0,
    output logic [31:0] coeff_word1,
    output logic [31:0] coeff_word2,
    output logic [31:0] coeff_word3,
    output logic [31:0] coeff_word4
);

    localparam int QW         = PHASE_BITS + 10;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (QW + DIV_STEP - 1) / DIV_STEP;
    localparam int PW         = DIV_STAGES * DIV_STEP;
    localparam int SH         = 30 - FRACTION_BITS;
    localparam logic [34:0] RND = 35'd1 << (SH - 1);

    // q30 value to signed fixed point with saturation
    function automatic logic [31:0] to_fixed(input logic signed [34:0] v);
        logic [34:0] sh;
        if (v > SAT_Q30)
        begin
            return POS_SAT;
        end
        else if (v < -SAT_Q30)
        begin
            return NEG_SAT;
        end
        else if (!v[34])
        begin
            sh = (35'(v) + RND) >> SH;
            return sh[31:0];
        end
        else
        begin
            sh = 35'(-v) >> SH;
            return 32'd0 - sh[31:0];
        end
    endfunction

    // sample rate register
    logic [9:0] fs_reg;
    logic [9:0] fs_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FS_RESET;
        end
        else if (cfg_write)
        begin
            fs_reg <= sample_rate_mhz;
        end
    end

    assign fs_eff = (fs_reg == 10'd0) ? 10'd1 : fs_reg;
    assign busy   = 1'b0;

    // phase numerator, pre-divided by 128, and r squared
    logic [16+PHASE_BITS:0] num_full;
    logic [31:0]            rr_sq;

    always_comb
    begin
        num_full = {1'b0, notch_freq, {PHASE_BITS{1'b0}}}
                 + (17+PHASE_BITS)'({fs_eff, 6'b0});
        rr_sq    = 32'(pole_radius) * 32'(pole_radius);
    end

    // phase divider pipeline
    logic          dvalid_reg [0:DIV_STAGES];
    logic [PW-1:0] dnum_reg   [0:DIV_STAGES];
    logic [9:0]    drem_reg   [0:DIV_STAGES];
    logic [29:0]   dr2_reg    [0:DIV_STAGES];
    logic [PW-1:0] dnum_next  [1:DIV_STAGES];
    logic [9:0]    drem_next  [1:DIV_STAGES];

    always_comb
    begin
        logic [10:0]   rw;
        logic [PW-1:0] nm;
        logic [9:0]    rm;
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            nm = dnum_reg[s-1];
            rm = drem_reg[s-1];
            for (int j = 0; j < DIV_STEP; j++)
            begin
                rw = {rm, nm[PW-1]};
                nm = {nm[PW-2:0], 1'b0};
                if (rw >= {1'b0, fs_eff})
                begin
                    rw    = rw - {1'b0, fs_eff};
                    nm[0] = 1'b1;
                end
                rm = rw[9:0];
            end
            dnum_next[s] = nm;
            drem_next[s] = rm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                dvalid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            dvalid_reg[0] <= start && !busy;
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                dvalid_reg[s] <= dvalid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dnum_reg[0] <= PW'(num_full[16+PHASE_BITS:7]);
        drem_reg[0] <= 10'd0;
        dr2_reg[0]  <= rr_sq[31:2];
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            dnum_reg[s] <= dnum_next[s];
            drem_reg[s] <= drem_next[s];
            dr2_reg[s]  <= dr2_reg[s-1];
        end
    end

    // cosine of the phase
    logic               cos_valid;
    logic signed [15:0] cos_val;
    logic [29:0]        cos_r2;

    ncg_cos #(
        .PHASE_BITS (PHASE_BITS),
        .TAG_W      (30)
    ) u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dvalid_reg[DIV_STAGES]),
        .phase     (dnum_reg[DIV_STAGES][PHASE_BITS-1:0]),
        .in_tag    (dr2_reg[DIV_STAGES]),
        .out_valid (cos_valid),
        .cos_q15   (cos_val),
        .out_tag   (cos_r2)
    );

    // magnitude of c2
    logic        t1_valid_reg, t2_valid_reg, done_reg;
    logic [30:0] g1_reg, g2_reg;
    logic        s1_reg, s2_reg;
    logic [29:0] r2a_reg, r2b_reg, c1_reg;
    logic [30:0] p5_reg, p7_reg, p9_reg;
    logic [31:0] sq_reg;
    logic [31:0] w0_reg, w1_reg, w2_reg, w3_reg, w4_reg;

    logic [14:0] cabs;
    logic [45:0] g_prod;
    logic [30:0] opr2;

    always_comb
    begin
        cabs   = cos_val[15] ? 15'(16'd0 - cos_val) : cos_val[14:0];
        opr2   = Q30_ONE + 31'(cos_r2);
        g_prod = 46'(opr2) * 46'(cabs);
    end

    // products of c2 with c1, one minus c1, c4 and itself
    logic [29:0] c1_nx, om;
    logic [60:0] pr5, pr7, pr9;
    logic [61:0] prsq;

    always_comb
    begin
        c1_nx = 30'((Q30_ONE + 31'(r2a_reg)) >> 1);
        om    = 30'(Q30_ONE - 31'(c1_nx));
        pr5   = 61'(g1_reg) * 61'(om);
        pr7   = 61'(c1_nx) * 61'(g1_reg);
        pr9   = 61'(g1_reg) * 61'(r2a_reg);
        prsq  = 62'(g1_reg) * 62'(g1_reg);
    end

    // signed coefficients and conversion
    logic signed [34:0] c1v, c2v, c3v, c4v, c5v, c6v, c7v, c8v, c9v;
    logic [31:0]        f1, f2, f3, f4, f5, f6, f7, f8, f9;

    always_comb
    begin
        c1v = $signed(35'(c1_reg));
        c2v = s2_reg ? -$signed(35'(g2_reg)) : $signed(35'(g2_reg));
        c3v = -c2v;
        c4v = -$signed(35'(r2b_reg));
        c5v = s2_reg ? -$signed(35'(p5_reg)) : $signed(35'(p5_reg));
        c6v = $signed(35'(c1_reg)) - $signed(35'(sq_reg));
        c7v = s2_reg ? $signed(35'(p7_reg)) : -$signed(35'(p7_reg));
        c8v = $signed(35'(sq_reg)) - $signed(35'(r2b_reg));
        c9v = s2_reg ? -$signed(35'(p9_reg)) : $signed(35'(p9_reg));
        f1  = to_fixed(c1v);
        f2  = to_fixed(c2v);
        f3  = to_fixed(c3v);
        f4  = to_fixed(c4v);
        f5  = to_fixed(c5v);
        f6  = to_fixed(c6v);
        f7  = to_fixed(c7v);
        f8  = to_fixed(c8v);
        f9  = to_fixed(c9v);
    end

    // output stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= cos_valid;
            t2_valid_reg <= t1_valid_reg;
            done_reg     <= t2_valid_reg;
        end
    end

    // coefficient data path
    always_ff @(posedge clk)
    begin
        g1_reg  <= g_prod[45:15];
        s1_reg  <= !cos_val[15];
        r2a_reg <= cos_r2;

        g2_reg  <= g1_reg;
        s2_reg  <= s1_reg;
        r2b_reg <= r2a_reg;
        c1_reg  <= c1_nx;
        p5_reg  <= pr5[60:30];
        p7_reg  <= pr7[60:30];
        p9_reg  <= pr9[60:30];
        sq_reg  <= prsq[61:30];

        w0_reg <= {f2[15:0], f1[15:0]};
        w1_reg <= {f4[15:0], f3[15:0]};
        w2_reg <= {f7[15:0], f5[15:0]};
        w3_reg <= {f8[15:0], f6[15:0]};
        w4_reg <= {f8[16], f6[16], 14'd0, f9[15:0]};
    end

    assign done        = done_reg;
    assign coeff_word0 = w0_reg;
    assign coeff_word1 = w1_reg;
    assign coeff_word2 = w2_reg;
    assign coeff_word3 = w3_reg;
    assign coeff_word4 = w4_reg;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb
    import ncg_pkg::*;
();

    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  REPORT_LIMIT   = 10;
    localparam int  COEF_FBITS     = 14;
    localparam int  PH_BITS        = 16;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    // five packed coefficient words of one transaction
    typedef struct packed {
        logic [31:0] w4;
        logic [31:0] w3;
        logic [31:0] w2;
        logic [31:0] w1;
        logic [31:0] w0;
    } coeff_set_t;

    typedef struct {
        logic [15:0] nf;
        logic [15:0] rr;
    } tune_req_t;

    // coefficient predictor and queue of expected coefficient sets
    class coeff_scoreboard;
        coeff_set_t expected_sets[$];
        logic [9:0] rate_mhz;
        int         mismatches;
        int         orphans;
        int         checked;

        function new();
            rate_mhz   = FS_RESET;
            mismatches = 0;
            orphans    = 0;
            checked    = 0;
        endfunction

        function void set_rate(logic [9:0] v);
            rate_mhz = v;
        endfunction

        function int pending();
            return expected_sets.size();
        endfunction

        function longint unsigned cos_series(longint unsigned x);
            longint unsigned x2;
            longint unsigned h;
            x2 = (x * x) >> 30;
            h  = ONE_Q30 - x2 / 56;
            h  = ONE_Q30 - ((x2 * h) >> 30) / 30;
            h  = ONE_Q30 - ((x2 * h) >> 30) / 12;
            h  = ONE_Q30 - ((x2 * h) >> 30) / 2;
            return h;
        endfunction

        function longint unsigned sin_series(longint unsigned x);
            longint unsigned x2;
            longint unsigned h;
            x2 = (x * x) >> 30;
            h  = ONE_Q30 - x2 / 42;
            h  = ONE_Q30 - ((x2 * h) >> 30) / 20;
            h  = ONE_Q30 - ((x2 * h) >> 30) / 6;
            return (x * h) >> 30;
        endfunction

        // cosine over one quarter turn, folded at the eighth
        function longint unsigned quarter_cosine(longint unsigned t);
            longint unsigned hp;
            hp = longint'(HALF_PI_Q30);
            if (t <= (ONE_Q30 >> 1))
                return cos_series((t * hp) >> 30);
            return sin_series(((ONE_Q30 - t) * hp) >> 30);
        endfunction

        function longint cosine_q15(longint unsigned phase);
            longint unsigned p32;
            longint unsigned quad;
            longint unsigned t;
            longint unsigned m;
            p32  = (phase << (32 - PH_BITS)) & 64'hFFFF_FFFF;
            quad = p32 >> 30;
            t    = p32 & (ONE_Q30 - 1);
            m    = quad[0] ? quarter_cosine(ONE_Q30 - t) : quarter_cosine(t);
            m    = (m + (64'd1 << 14)) >> 15;
            if (m > 32767)
                m = 32767;
            return (quad == 1 || quad == 2) ? -longint'(m) : longint'(m);
        endfunction

        // product on magnitudes, truncated toward zero, then signed
        function longint signed_product(longint a, longint b, int sh);
            longint unsigned ma;
            longint unsigned mb;
            longint unsigned m;
            ma = (a < 0) ? longint'(-a) : a;
            mb = (b < 0) ? longint'(-b) : b;
            m  = (ma * mb) >> sh;
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        function logic [31:0] q30_to_q14(longint v);
            longint unsigned m;
            longint          sat;
            sat = longint'(SAT_Q30);
            if (v > sat)
                return POS_SAT;
            if (v < -sat)
                return NEG_SAT;
            if (v >= 0)
            begin
                m = (longint'(v) + (64'd1 << (29 - COEF_FBITS))) >> (30 - COEF_FBITS);
                return m[31:0];
            end
            m = longint'(-v) >> (30 - COEF_FBITS);
            return 32'd0 - m[31:0];
        endfunction

        function coeff_set_t compute_coeffs(logic [15:0] nf, logic [15:0] rr);
            coeff_set_t      s;
            longint unsigned fs;
            longint unsigned phase;
            longint          cv;
            longint          r2, opr2, c1, c2, c3, c4, c5, c6, c7, c8, c9;
            logic [31:0]     f1, f2, f3, f4, f5, f6, f7, f8, f9;
            fs    = (rate_mhz == 0) ? 1 : rate_mhz;
            phase = (((longint'(nf) << PH_BITS) + 64 * fs) / (128 * fs))
                    & ((64'd1 << PH_BITS) - 1);
            cv    = cosine_q15(phase);
            r2    = (longint'(rr) * longint'(rr)) >>> 2;
            opr2  = longint'(ONE_Q30) + r2;
            c1    = opr2 >>> 1;
            c2    = -signed_product(opr2, cv, 15);
            c3    = -c2;
            c4    = -r2;
            c5    = signed_product(c2, longint'(ONE_Q30) - c1, 30);
            c6    = c1 + signed_product(c3, c2, 30);
            c7    = signed_product(c1, c3, 30);
            c8    = signed_product(c2, c2, 30) + c4;
            c9    = signed_product(c3, c4, 30);
            f1 = q30_to_q14(c1); f2 = q30_to_q14(c2); f3 = q30_to_q14(c3);
            f4 = q30_to_q14(c4); f5 = q30_to_q14(c5); f6 = q30_to_q14(c6);
            f7 = q30_to_q14(c7); f8 = q30_to_q14(c8); f9 = q30_to_q14(c9);
            s.w0 = {f2[15:0], f1[15:0]};
            s.w1 = {f4[15:0], f3[15:0]};
            s.w2 = {f7[15:0], f5[15:0]};
            s.w3 = {f8[15:0], f6[15:0]};
            s.w4 = {f8[16], f6[16], 14'd0, f9[15:0]};
            return s;
        endfunction

        function void note_request(logic [15:0] nf, logic [15:0] rr);
            expected_sets.push_back(compute_coeffs(nf, rr));
        endfunction

        function void report_word(int idx, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch coeff_word%0d: expected %h, got %h", idx, e, a);
            end
        endfunction

        function void check_result(coeff_set_t got);
            coeff_set_t e;
            if (expected_sets.size() == 0)
            begin
                orphans++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected coefficient set %h", got);
                return;
            end
            e = expected_sets.pop_front();
            checked++;
            report_word(0, e.w0, got.w0);
            report_word(1, e.w1, got.w1);
            report_word(2, e.w2, got.w2);
            report_word(3, e.w3, got.w3);
            report_word(4, e.w4, got.w4);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] notch_freq;
    logic [15:0] pole_radius;
    logic        cfg_write;
    logic [9:0]  sample_rate_mhz;
    logic        done;
    logic [31:0] coeff_word0, coeff_word1, coeff_word2, coeff_word3, coeff_word4;

    coeff_scoreboard sb;
    tune_req_t       stim_q[$];
    int              idle_cycles = 0;
    int              burst_left;
    int              gap_left;
    int              rates_seen;

    notch_filter_coefficient_generator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .notch_freq      (notch_freq),
        .pole_radius     (pole_radius),
        .cfg_write       (cfg_write),
        .sample_rate_mhz (sample_rate_mhz),
        .done            (done),
        .coeff_word0     (coeff_word0),
        .coeff_word1     (coeff_word1),
        .coeff_word2     (coeff_word2),
        .coeff_word3     (coeff_word3),
        .coeff_word4     (coeff_word4)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // monitor: note accepted requests and check coefficient sets
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (start && !busy)
                sb.note_request(notch_freq, pole_radius);
            if (done)
                sb.check_result({coeff_word4, coeff_word3, coeff_word2,
                                 coeff_word1, coeff_word0});
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("[notch_filter_coefficient_generator] ERROR");
            $finish;
        end
    end

    task automatic add_req(logic [15:0] nf, logic [15:0] rr);
        tune_req_t t;
        t.nf = nf;
        t.rr = rr;
        stim_q.push_back(t);
    endtask

    // drive queued requests in bursts with random gaps
    task automatic send_requests();
        while (stim_q.size() > 0)
        begin
            @(posedge clk);
            if (start && !busy)
            begin
                void'(stim_q.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (stim_q.size() == 0)
                start <= 1'b0;
            else if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else
            begin
                start       <= 1'b1;
                notch_freq  <= stim_q[0].nf;
                pole_radius <= stim_q[0].rr;
            end
        end
    endtask

    // rate register is only written with the pipeline empty
    task automatic write_rate(logic [9:0] v);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write       <= 1'b1;
        sample_rate_mhz <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_rate(v);
        rates_seen++;
    endtask

    task automatic add_random(int n, logic [9:0] rate);
        int          fsv;
        int          k;
        logic [15:0] nf;
        logic [15:0] rr;
        fsv = (rate == 0) ? 1 : int'(rate);
        repeat (n)
        begin
            // frequency: full range or near multiples of an eighth turn
            if ($urandom_range(0, 9) < 6)
                nf = 16'($urandom);
            else
            begin
                k  = $urandom_range(0, 15);
                nf = 16'((k * fsv * 16) + $urandom_range(0, 6) - 3);
            end
            // radius: full range, close to one, or extremes
            case ($urandom_range(0, 3))
                0, 1: rr = 16'($urandom);
                2:    rr = 16'hF000 | 16'($urandom_range(0, 16'h0FFF));
                default:
                begin
                    k  = $urandom_range(0, 2);
                    rr = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'h8000;
                end
            endcase
            add_req(nf, rr);
        end
    endtask

    initial
    begin
        logic [9:0] rnd_rate;
        sb              = new();
        rst_n           = 1'b0;
        start           = 1'b0;
        notch_freq      = 16'd0;
        pole_radius     = 16'd0;
        cfg_write       = 1'b0;
        sample_rate_mhz = FS_RESET;
        burst_left      = 1;
        gap_left        = 0;
        rates_seen      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset rate, turn boundaries, folding point, field extremes
        add_req(16'd0,     16'h0000);
        add_req(16'hFFFF,  16'hFFFF);
        add_req(16'd0,     16'hFFFF);
        add_req(16'hFFFF,  16'h0000);
        add_req(16'd8000,  16'h8000);
        add_req(16'd16000, 16'hFFFF);
        add_req(16'd32000, 16'hFFFF);
        add_req(16'd48000, 16'hC000);
        add_req(16'd64000, 16'hFFFF);
        add_req(16'd64001, 16'h0001);
        add_req(16'd7999,  16'hFFFE);
        add_req(16'd8001,  16'hF0F0);
        add_req(16'hAAAA,  16'h5555);
        add_req(16'h5555,  16'hAAAA);
        add_req(16'd24000, 16'hE000);
        add_req(16'd40000, 16'h4000);
        send_requests();
        add_random(300, FS_RESET);
        send_requests();

        // extremes of the rate register, zero taken as one
        write_rate(10'd1023);
        add_req(16'hFFFF, 16'hFFFF);
        add_random(280, 10'd1023);
        send_requests();
        write_rate(10'd1);
        add_req(16'd128, 16'hFFFF);
        add_req(16'd32,  16'hFFFF);
        add_random(200, 10'd1);
        send_requests();
        write_rate(10'd0);
        add_req(16'd64, 16'hFFFF);
        add_random(200, 10'd0);
        send_requests();

        // random rates
        repeat (2)
        begin
            rnd_rate = 10'($urandom);
            write_rate(rnd_rate);
            add_random(350, rnd_rate);
            send_requests();
        end

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d coefficient sets over %0d sample rate settings",
                 sb.checked, rates_seen + 1);
        $display("rates covered reset, 1, 1023, zero and random values");
        if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending() == 0)
            $display("[notch_filter_coefficient_generator] OK");
        else
        begin
            $display("%0d mismatches, %0d sets left over", sb.mismatches, sb.pending());
            $display("[notch_filter_coefficient_generator] ERROR");
        end
        $finish;
    end

endmodule
